// ===== rtl/ilee_pkg.sv =====
// ----------------------------------------------------------------------------
// ilee_pkg
// shared types and constants of the ising lattice energy engine
// ----------------------------------------------------------------------------
package ilee_pkg;

  localparam int ROW_W       = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int DELTA_W     = 6;
  localparam int ENERGY_W    = 17;
  localparam int MAG_W       = 14;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 1;
  localparam int H_W         = 5;
  localparam int CFG_DATA_W  = H_W;
  localparam int QPH_W       = 3;

  localparam logic [QPH_W-1:0] QPH_LAST = 3'd4;

  localparam logic signed [H_W-1:0] H_MIN = -5'sd8;
  localparam logic signed [H_W-1:0] H_MAX = 5'sd8;

  localparam int ENERGY_MAX = 65535;
  localparam int ENERGY_MIN = -65536;
  localparam int MAG_MAX    = 8191;
  localparam int MAG_MIN    = -8192;

  localparam logic [CFG_IDX_W-1:0] CFG_FILL_NEG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_H  = 1'b1;

  typedef enum logic [1:0] {
    REQ_FILL   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_TOTALS = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    WS_ZERO = 2'd0,
    WS_FILL = 2'd1,
    WS_ITEM = 2'd2
  } wsrc_t;

  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_QUERY = 2'd1,
    RD_SCAN  = 2'd2
  } rd_t;

  typedef struct packed {
    logic  load;
    logic  we;
    wsrc_t wsrc;
    rd_t   rd;
    logic  sw_step;
    logic  fin1;
    logic  fin2;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic q_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/ilee_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilee_ctrl
// request sequencer: clear pass, fill and totals sweeps, query reads, output
// ----------------------------------------------------------------------------
module ilee_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ilee_pkg::IN_TUSER_W-1:0] in_tuser,
  input  ilee_pkg::stat_t                 stat,
  output ilee_pkg::cmd_t                  cmd
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_FILL  = 11'b000_0000_0100,
    S_WRITE = 11'b000_0000_1000,
    S_QRD   = 11'b000_0001_0000,
    S_QWAIT = 11'b000_0010_0000,
    S_SCAN  = 11'b000_0100_0000,
    S_SWAIT = 11'b000_1000_0000,
    S_FIN1  = 11'b001_0000_0000,
    S_FIN2  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t         state_r;
  state_t         state_nxt;
  ilee_pkg::req_t req;

  assign req = ilee_pkg::req_t'(in_tuser);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.we      = 1'b1;
        cmd.wsrc    = ilee_pkg::WS_ZERO;
        cmd.sw_step = 1'b1;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          unique case (req)
            ilee_pkg::REQ_FILL:   state_nxt = S_FILL;
            ilee_pkg::REQ_WRITE:  state_nxt = S_WRITE;
            ilee_pkg::REQ_QUERY:  state_nxt = S_QRD;
            ilee_pkg::REQ_TOTALS: state_nxt = S_SCAN;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_FILL: begin
        cmd.we      = 1'b1;
        cmd.wsrc    = ilee_pkg::WS_FILL;
        cmd.sw_step = 1'b1;
        if (stat.sweep_last) state_nxt = S_DONE;
      end
      S_WRITE: begin
        cmd.we    = 1'b1;
        cmd.wsrc  = ilee_pkg::WS_ITEM;
        state_nxt = S_DONE;
      end
      S_QRD: begin
        cmd.rd = ilee_pkg::RD_QUERY;
        if (stat.q_last) state_nxt = S_QWAIT;
      end
      S_QWAIT: begin
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        cmd.rd      = ilee_pkg::RD_SCAN;
        cmd.sw_step = 1'b1;
        if (stat.sweep_last) state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        state_nxt = S_FIN1;
      end
      S_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        cmd.fin2  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ilee_dpath.sv =====
// ----------------------------------------------------------------------------
// ilee_dpath
// spin memory, sweep and query addressing, bond and spin counters, output reg
// ----------------------------------------------------------------------------
module ilee_dpath #(
  parameter int SIDE = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ilee_pkg::cmd_t                   cmd,
  output ilee_pkg::stat_t                  stat,
  input  logic [ilee_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [ilee_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ilee_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ilee_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ilee_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int N  = SIDE * SIDE;
  localparam int AW = $clog2(N);
  localparam int IW = $clog2(SIDE);
  localparam int CW = $clog2(2 * N + 1);
  localparam int SW = CW + 2;
  localparam int PW = SW + ilee_pkg::H_W;
  localparam int EW = (PW + 1 > ilee_pkg::ENERGY_W + 1) ? PW + 1 : ilee_pkg::ENERGY_W + 1;
  localparam int MW = ((SW > ilee_pkg::MAG_W + 1) ? SW : ilee_pkg::MAG_W + 1) + 1;
  localparam int PAD_W = ilee_pkg::OUT_TDATA_W - ilee_pkg::DELTA_W
                         - ilee_pkg::ENERGY_W - ilee_pkg::MAG_W;

  localparam logic [IW-1:0]        LAST_IDX = IW'(SIDE - 1);
  localparam logic signed [EW-1:0] E_MAX    = EW'(ilee_pkg::ENERGY_MAX);
  localparam logic signed [EW-1:0] E_MIN    = EW'(ilee_pkg::ENERGY_MIN);
  localparam logic signed [MW-1:0] M_MAX    = MW'(ilee_pkg::MAG_MAX);
  localparam logic signed [MW-1:0] M_MIN    = MW'(ilee_pkg::MAG_MIN);

  typedef enum logic [1:0] {
    RT_NONE = 2'd0,
    RT_SITE = 2'd1,
    RT_NBR  = 2'd2,
    RT_SCAN = 2'd3
  } rtag_t;

  function automatic logic [AW-1:0] site_addr(input logic [IW-1:0] r,
                                               input logic [IW-1:0] c);
    return AW'(AW'(r) * AW'(SIDE) + AW'(c));
  endfunction

  function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] v);
    return (v == '0) ? LAST_IDX : IW'(v - 1'b1);
  endfunction

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    return (v == LAST_IDX) ? '0 : IW'(v + 1'b1);
  endfunction

  // spin memory, 1 means -1
  logic mem [N];
  logic rdata_r;

  // configuration
  logic                          fneg_r;
  logic signed [ilee_pkg::H_W-1:0] fh_r;
  logic signed [ilee_pkg::H_W-1:0] h_sat;

  // current item
  ilee_pkg::req_t it_req_r;
  logic [IW-1:0]  it_r_r;
  logic [IW-1:0]  it_c_r;
  logic           it_spin_r;
  logic [IW-1:0]  row_m;
  logic [IW-1:0]  col_m;

  // addressing
  logic [IW-1:0]              sw_r_r;
  logic [IW-1:0]              sw_c_r;
  logic [ilee_pkg::QPH_W-1:0] ph_r;
  logic [AW-1:0]              qaddr;
  logic [AW-1:0]              addr;
  logic                       wdata;

  // read tracking
  rtag_t         rtag_r;
  rtag_t         rtag_nxt;
  logic [IW-1:0] rr_r;
  logic [IW-1:0] rc_r;

  // accumulators
  logic            s_site_r;
  logic [2:0]      nd_r;
  logic [CW-1:0]   dc_r;
  logic [CW-1:0]   df_r;
  logic [CW-1:0]   df_nxt;
  logic            prev_r;
  logic            rowfirst_r;
  logic [SIDE-1:0] lb_r;
  logic [SIDE-1:0] fb_r;
  logic            h1;
  logic            h2;
  logic            v1;
  logic            v2;

  // totals finish
  logic signed [SW-1:0] mag_r;
  logic signed [SW-1:0] bnd_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] hx;
  logic signed [PW-1:0] mx;
  logic signed [EW-1:0] en;
  logic signed [EW-1:0] en_sat;
  logic signed [MW-1:0] mg;
  logic signed [MW-1:0] mg_sat;

  // query result
  logic [6:0]                   t7;
  logic [6:0]                   d7;
  logic [ilee_pkg::DELTA_W-1:0] delta;

  // output
  logic                             out_valid_r;
  logic [ilee_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [ilee_pkg::OUT_TDATA_W-1:0] out_data_nxt;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign stat.sweep_last = (sw_r_r == LAST_IDX) && (sw_c_r == LAST_IDX);
  assign stat.q_last     = (ph_r == ilee_pkg::QPH_LAST);
  assign stat.out_free   = !out_valid_r || out_tready;

  always_comb begin
    if (fh_r < ilee_pkg::H_MIN) begin
      h_sat = ilee_pkg::H_MIN;
    end else if (fh_r > ilee_pkg::H_MAX) begin
      h_sat = ilee_pkg::H_MAX;
    end else begin
      h_sat = fh_r;
    end
  end

  // coordinate wrap by constant table
  always_comb begin
    row_m = '0;
    col_m = '0;
    for (int k = 0; k < 2 ** ilee_pkg::ROW_W; k++) begin
      if (in_tdata[ilee_pkg::ROW_W-1:0] == ilee_pkg::ROW_W'(k)) row_m = IW'(k % SIDE);
      if (in_tdata[2*ilee_pkg::ROW_W-1:ilee_pkg::ROW_W] == ilee_pkg::ROW_W'(k)) begin
        col_m = IW'(k % SIDE);
      end
    end
  end

  always_comb begin
    unique case (ph_r)
      3'd0:    qaddr = site_addr(it_r_r, it_c_r);
      3'd1:    qaddr = site_addr(it_r_r, wrap_dec(it_c_r));
      3'd2:    qaddr = site_addr(wrap_dec(it_r_r), it_c_r);
      3'd3:    qaddr = site_addr(wrap_inc(it_r_r), it_c_r);
      3'd4:    qaddr = site_addr(it_r_r, wrap_inc(it_c_r));
      default: qaddr = site_addr(it_r_r, it_c_r);
    endcase
  end

  always_comb begin
    priority if (cmd.rd == ilee_pkg::RD_QUERY) begin
      addr = qaddr;
    end else if (cmd.sw_step) begin
      addr = site_addr(sw_r_r, sw_c_r);
    end else begin
      addr = site_addr(it_r_r, it_c_r);
    end
  end

  always_comb begin
    unique case (cmd.wsrc)
      ilee_pkg::WS_ZERO: wdata = 1'b0;
      ilee_pkg::WS_FILL: wdata = fneg_r;
      ilee_pkg::WS_ITEM: wdata = it_spin_r;
      default:           wdata = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) mem[addr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[addr];
  end

  always_comb begin
    unique case (cmd.rd)
      ilee_pkg::RD_QUERY: rtag_nxt = (ph_r == '0) ? RT_SITE : RT_NBR;
      ilee_pkg::RD_SCAN:  rtag_nxt = RT_SCAN;
      default:            rtag_nxt = RT_NONE;
    endcase
  end

  // bonds whose ends disagree, seen at the later end in scan order
  always_comb begin
    h1     = (rc_r != '0) && (rdata_r ^ prev_r);
    h2     = (rc_r == LAST_IDX) && (rdata_r ^ rowfirst_r);
    v1     = (rr_r != '0) && (rdata_r ^ lb_r[SIDE-1]);
    v2     = (rr_r == LAST_IDX) && (rdata_r ^ fb_r[SIDE-1]);
    df_nxt = CW'(df_r + CW'(h1) + CW'(h2) + CW'(v1) + CW'(v2));
  end

  always_comb begin
    hx = {{(PW-ilee_pkg::H_W){h_sat[ilee_pkg::H_W-1]}}, h_sat};
    mx = {{(PW-SW){mag_r[SW-1]}}, mag_r};
    en = {{(EW-SW){bnd_r[SW-1]}}, bnd_r} - {{(EW-PW){prod_r[PW-1]}}, prod_r};
    mg = {{(MW-SW){mag_r[SW-1]}}, mag_r};
    priority if (en > E_MAX) begin
      en_sat = E_MAX;
    end else if (en < E_MIN) begin
      en_sat = E_MIN;
    end else begin
      en_sat = en;
    end
    priority if (mg > M_MAX) begin
      mg_sat = M_MAX;
    end else if (mg < M_MIN) begin
      mg_sat = M_MIN;
    end else begin
      mg_sat = mg;
    end
  end

  always_comb begin
    t7    = 7'd4 - 7'({nd_r, 1'b0}) + {{2{h_sat[ilee_pkg::H_W-1]}}, h_sat};
    d7    = s_site_r ? 7'(7'd0 - {t7[5:0], 1'b0}) : {t7[5:0], 1'b0};
    delta = d7[ilee_pkg::DELTA_W-1:0];
  end

  always_comb begin
    out_data_nxt = '0;
    unique case (it_req_r)
      ilee_pkg::REQ_QUERY: begin
        out_data_nxt = {PAD_W'(0), ilee_pkg::MAG_W'(0), ilee_pkg::ENERGY_W'(0), delta};
      end
      ilee_pkg::REQ_TOTALS: begin
        out_data_nxt = {PAD_W'(0), mg_sat[ilee_pkg::MAG_W-1:0],
                        en_sat[ilee_pkg::ENERGY_W-1:0], ilee_pkg::DELTA_W'(0)};
      end
      default: begin
        out_data_nxt = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fneg_r      <= 1'b0;
      fh_r        <= '0;
      sw_r_r      <= '0;
      sw_c_r      <= '0;
      ph_r        <= '0;
      rtag_r      <= RT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          ilee_pkg::CFG_FILL_NEG: fneg_r <= cfg_data[0];
          ilee_pkg::CFG_FIELD_H:  fh_r   <= cfg_data;
          default:                fh_r   <= fh_r;
        endcase
      end
      if (cmd.sw_step) begin
        sw_c_r <= wrap_inc(sw_c_r);
        if (sw_c_r == LAST_IDX) sw_r_r <= wrap_inc(sw_r_r);
      end
      if (cmd.load) begin
        ph_r <= '0;
      end else if (cmd.rd == ilee_pkg::RD_QUERY) begin
        ph_r <= ilee_pkg::QPH_W'(ph_r + 1'b1);
      end
      rtag_r <= rtag_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rr_r <= sw_r_r;
    rc_r <= sw_c_r;
    if (cmd.load) begin
      it_req_r  <= ilee_pkg::req_t'(in_tuser);
      it_r_r    <= row_m;
      it_c_r    <= col_m;
      it_spin_r <= in_tdata[2*ilee_pkg::ROW_W];
      nd_r      <= '0;
      dc_r      <= '0;
      df_r      <= '0;
    end else begin
      unique case (rtag_r)
        RT_SITE: s_site_r <= rdata_r;
        RT_NBR:  nd_r     <= 3'(nd_r + 3'(rdata_r));
        RT_SCAN: begin
          dc_r   <= CW'(dc_r + CW'(rdata_r));
          df_r   <= df_nxt;
          prev_r <= rdata_r;
          if (rc_r == '0) rowfirst_r <= rdata_r;
          lb_r <= {lb_r[SIDE-2:0], rdata_r};
          if (rr_r == '0) begin
            fb_r <= {fb_r[SIDE-2:0], rdata_r};
          end else if (rr_r == LAST_IDX) begin
            fb_r <= {fb_r[SIDE-2:0], fb_r[SIDE-1]};
          end
        end
        default: begin
          nd_r <= nd_r;
        end
      endcase
    end
    if (cmd.fin1) begin
      mag_r <= SW'(N) - SW'({dc_r, 1'b0});
      bnd_r <= SW'({df_r, 1'b0}) - SW'(2 * N);
    end
    if (cmd.fin2) begin
      prod_r <= PW'(hx * mx);
    end
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== rtl/ising_lattice_energy_engine.sv =====
// ----------------------------------------------------------------------------
// ising_lattice_energy_engine
// periodic ising lattice with spin fill, spin write, flip energy and totals
// ----------------------------------------------------------------------------
// All spins live in one SIDE*SIDE by 1-bit memory with a single port, and
// that port sets the time of every request. After reset the block runs a
// clearing pass over every site, then takes requests one at a time and
// returns one result transaction for each. A flip energy query makes five
// reads (the site and its four neighbors); a fill writes every site and a
// totals request reads every site, one site per cycle, with line buffers
// for the wrapped neighbor bonds. The next request is taken while the
// previous result waits on the output. Configuration writes are taken in
// any cycle.
module ising_lattice_energy_engine #(
  parameter int SIDE = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // tdata: row[5:0], col[11:6], spin_down[12], zero[15:13]
  input  logic [ilee_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: req_type[1:0]
  input  logic [ilee_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: flip_delta[5:0], total_energy[22:6], magnetisation[36:23], zero[39:37]
  output logic [ilee_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ilee_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ilee_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ilee_pkg::cmd_t  cmd;
  ilee_pkg::stat_t stat;

  ilee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  ilee_dpath #(
    .SIDE (SIDE)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== test/ising_lattice_energy_monitor.sv =====
// ----------------------------------------------------------------------------
// ising_lattice_energy_monitor
// watches the request, result and register channels of the lattice engine,
// keeps its own copy of the spin lattice and registers, works out the result
// owed for every accepted request and compares each result transaction with
// the oldest one owed, field by field
// ----------------------------------------------------------------------------
module ising_lattice_energy_monitor #(
  parameter int SIDE = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [ilee_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [ilee_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [ilee_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ilee_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ilee_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ilee_pkg::*;

  typedef struct {
    logic signed [DELTA_W-1:0]  delta;
    logic signed [ENERGY_W-1:0] energy;
    logic signed [MAG_W-1:0]    mag;
  } lattice_result_t;

  lattice_result_t       owed_results[$];
  bit                    spin_neg[SIDE*SIDE];
  bit                    fill_neg;
  logic signed [H_W-1:0] field_reg;
  int                    fails = 0;
  int                    mismatches = 0;
  int                    owed_cnt = 0;

  assign fail_count = fails;
  assign pending    = owed_cnt;

  function automatic int spin_of(int r, int c);
    return spin_neg[(r % SIDE) * SIDE + (c % SIDE)] ? -1 : 1;
  endfunction

  function automatic int neighbor_sum(int r, int c);
    return spin_of(r, c + SIDE - 1) + spin_of(r + SIDE - 1, c) +
           spin_of(r + 1, c) + spin_of(r, c + 1);
  endfunction

  function automatic lattice_result_t apply_request(req_t req, int r, int c, bit down);
    lattice_result_t res;
    int              h;
    int              s;
    int              energy;
    int              mag;
    int              i;
    int              j;
    h      = field_reg;
    energy = 0;
    mag    = 0;
    if (h < int'(H_MIN)) h = H_MIN;
    if (h > int'(H_MAX)) h = H_MAX;
    res.delta  = '0;
    res.energy = '0;
    res.mag    = '0;
    case (req)
      REQ_FILL: begin
        for (i = 0; i < SIDE * SIDE; i++) spin_neg[i] = fill_neg;
      end
      REQ_WRITE: begin
        spin_neg[r * SIDE + c] = down;
      end
      REQ_QUERY: begin
        res.delta = DELTA_W'(2 * spin_of(r, c) * (neighbor_sum(r, c) + h));
      end
      default: begin
        for (i = 0; i < SIDE; i++) begin
          for (j = 0; j < SIDE; j++) begin
            s = spin_of(i, j);
            energy -= s * (neighbor_sum(i, j) / 2 + h);
            mag += s;
          end
        end
        if (energy > ENERGY_MAX) energy = ENERGY_MAX;
        if (energy < ENERGY_MIN) energy = ENERGY_MIN;
        if (mag > MAG_MAX) mag = MAG_MAX;
        if (mag < MAG_MIN) mag = MAG_MIN;
        res.energy = ENERGY_W'(energy);
        res.mag    = MAG_W'(mag);
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string name, int expv, int actv);
    if (expv != actv) begin
      fails++;
      if (mismatches < 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, expv, actv);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    lattice_result_t want;
    lattice_result_t got;
    if (!rst_n) begin
      foreach (spin_neg[k]) spin_neg[k] = 1'b0;
      fill_neg  = 1'b0;
      field_reg = '0;
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FILL_NEG: fill_neg = cfg_data[0];
          CFG_FIELD_H:  field_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.delta  = out_tdata[DELTA_W-1:0];
        got.energy = out_tdata[DELTA_W +: ENERGY_W];
        got.mag    = out_tdata[DELTA_W+ENERGY_W +: MAG_W];
        if (owed_results.size() == 0) begin
          fails++;
          if (mismatches < 10)
            $display("%0t: result with none owed: delta %0d energy %0d mag %0d",
                     $realtime, got.delta, got.energy, got.mag);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          check_field("flip_delta", want.delta, got.delta);
          check_field("total_energy", want.energy, got.energy);
          check_field("magnetisation", want.mag, got.mag);
        end
      end
      if (in_tvalid && in_tready)
        owed_results.push_back(apply_request(req_t'(in_tuser),
                                             int'(in_tdata[ROW_W-1:0]) % SIDE,
                                             int'(in_tdata[2*ROW_W-1:ROW_W]) % SIDE,
                                             in_tdata[2*ROW_W]));
    end
    owed_cnt <= owed_results.size();
  end

endmodule

// ===== test/ising_lattice_energy_engine_tb.sv =====
// ----------------------------------------------------------------------------
// ising_lattice_energy_engine_tb
// stimulus and verdict for the ising lattice energy engine
// ----------------------------------------------------------------------------
// Drives directed fills, spin writes, flip queries and totals at the lattice
// corners and wrap edges under several register settings, including field
// values that must saturate, then random phases of mostly clustered writes
// and queries. The sender runs in bursts, the receiver stalls on its own
// pattern and once holds off long enough to back up the request channel.
// ----------------------------------------------------------------------------
module ising_lattice_energy_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ilee_pkg::*;

  localparam int SIDE        = 64;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int PHASE_ITEMS = 50;
  localparam int RAND_PHASES = 9;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int       fail_count;
  int       pending;
  int       burst_left = 0;
  bit       steady_sender = 1'b0;
  bit       hold_off_req = 1'b0;
  rx_mode_t rx_mode = RX_OPEN;
  int       hot_row = 0;
  int       hot_col = 0;
  longint   cycle_cnt = 0;

  ising_lattice_energy_engine #(.SIDE(SIDE)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ising_lattice_energy_monitor #(.SIDE(SIDE)) i_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : receiver
    int tick;
    tick = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        tick++;
        case (rx_mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
          default:   out_tready <= (tick % 7) >= 3;
        endcase
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(bit fill, int h);
    write_reg(CFG_FILL_NEG, CFG_DATA_W'(fill));
    write_reg(CFG_FIELD_H, CFG_DATA_W'(h));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_req(req_t req, int r, int c, bit down);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[ROW_W-1:0]       = r[ROW_W-1:0];
    word[2*ROW_W-1:ROW_W] = c[ROW_W-1:0];
    word[2*ROW_W]         = down;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady_sender) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    int pick;
    int r;
    int c;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 6) begin
      r = (hot_row + $urandom_range(0, 3)) % SIDE;
      c = (hot_col + $urandom_range(0, 3)) % SIDE;
    end else begin
      r = $urandom_range(0, SIDE - 1);
      c = $urandom_range(0, SIDE - 1);
    end
    if (pick < 4)
      send_req(REQ_FILL, r, c, $urandom_range(0, 1));
    else if (pick < 50)
      send_req(REQ_WRITE, r, c, $urandom_range(0, 1));
    else if (pick < 92)
      send_req(REQ_QUERY, r, c, $urandom_range(0, 1));
    else
      send_req(REQ_TOTALS, r, c, $urandom_range(0, 1));
  endtask

  initial begin : stimulus
    int ph;
    int n;
    int h;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: corners, wrap edges, fill both ways, saturating field
    set_config(1'b0, 0);
    send_req(REQ_TOTALS, 0, 0, 1'b0);
    send_req(REQ_QUERY, 0, 0, 1'b0);
    send_req(REQ_WRITE, 0, 0, 1'b1);
    send_req(REQ_WRITE, 63, 63, 1'b1);
    send_req(REQ_WRITE, 42, 21, 1'b1);
    send_req(REQ_WRITE, 21, 42, 1'b0);
    send_req(REQ_QUERY, 0, 0, 1'b1);
    send_req(REQ_QUERY, 63, 63, 1'b0);
    send_req(REQ_QUERY, 0, 63, 1'b1);
    send_req(REQ_QUERY, 63, 0, 1'b0);
    send_req(REQ_QUERY, 42, 21, 1'b0);
    send_req(REQ_TOTALS, 63, 63, 1'b1);
    send_req(REQ_FILL, 0, 0, 1'b0);
    send_req(REQ_TOTALS, 0, 0, 1'b0);
    drain();
    set_config(1'b1, -16);
    send_req(REQ_FILL, 63, 63, 1'b1);
    send_req(REQ_QUERY, 5, 5, 1'b0);
    send_req(REQ_WRITE, 5, 6, 1'b0);
    send_req(REQ_QUERY, 5, 5, 1'b1);
    send_req(REQ_TOTALS, 0, 0, 1'b0);
    drain();
    set_config(1'b1, 15);
    send_req(REQ_QUERY, 5, 6, 1'b0);
    send_req(REQ_TOTALS, 0, 0, 1'b0);
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       h = -8;
        1:       h = 8;
        2:       h = -16;
        3:       h = 15;
        default: h = $urandom_range(0, 31) - 16;
      endcase
      set_config($urandom_range(0, 1), h);
      hot_row       = $urandom_range(0, 1) ? SIDE - 2 : $urandom_range(0, SIDE - 1);
      hot_col       = $urandom_range(0, 1) ? SIDE - 2 : $urandom_range(0, SIDE - 1);
      steady_sender = (ph == 0);
      rx_mode       = (ph == 0) ? RX_OPEN : rx_mode_t'($urandom_range(0, 2));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 10) hold_off_req = 1'b1;
        send_random();
      end
      drain();
    end

    repeat (SIDE * SIDE + 16) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
